// File: rtl/b58_pkg.sv
package b58_pkg;

   localparam int MAX_BYTES_DEF = 32;
   localparam int RADIX         = 58;
   localparam int LOG_NUM       = 138;
   localparam int LOG_DEN       = 100;
   localparam int DIGIT_W       = 6;
   localparam int BYTE_W        = 8;
   localparam int CHAR_W        = 7;
   localparam int TAB_DEPTH     = 2 ** DIGIT_W;
   localparam int Y_W           = BYTE_W + 1;
   localparam int Q2_MAX        = (2 ** BYTE_W - 1 + RADIX - 1) / RADIX;
   localparam int Q2_W          = $clog2(Q2_MAX + 1);

   localparam logic [8*RADIX-1:0] ALPHABET =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef logic [BYTE_W-1:0]  quot_tab_type [TAB_DEPTH];
   typedef logic [DIGIT_W-1:0] rem_tab_type  [TAB_DEPTH];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRIME,
      ST_ABSORB,
      ST_TRIM_RD,
      ST_TRIM_CHK,
      ST_ONES,
      ST_DIG_RD,
      ST_DIG_OUT
   } state_type;

   // Quotient and remainder of 256 times each base-58 digit, divided by 58.
   function automatic quot_tab_type build_quot_tab();
      quot_tab_type t;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         if (k < RADIX) begin
            t[k] = BYTE_W'((256 * k) / RADIX);
         end else begin
            t[k] = '0;
         end
      end
      return t;
   endfunction

   function automatic rem_tab_type build_rem_tab();
      rem_tab_type t;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         if (k < RADIX) begin
            t[k] = DIGIT_W'((256 * k) % RADIX);
         end else begin
            t[k] = '0;
         end
      end
      return t;
   endfunction

   localparam quot_tab_type QUOT_TAB = build_quot_tab();
   localparam rem_tab_type  REM_TAB  = build_rem_tab();

   function automatic logic [CHAR_W-1:0] b58_char(input logic [DIGIT_W-1:0] d);
      logic [7:0] c;
      if (d < DIGIT_W'(RADIX)) begin
         c = ALPHABET[8*(RADIX-1-int'(d)) +: 8];
      end else begin
         c = "1";
      end
      return c[CHAR_W-1:0];
   endfunction

endpackage

// File: rtl/b58_ram.sv
module b58_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 45
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/b58_digit_unit.sv
module b58_digit_unit (
   input  logic [b58_pkg::DIGIT_W-1:0] digit,
   input  logic [b58_pkg::BYTE_W-1:0]  carry,
   output logic [b58_pkg::DIGIT_W-1:0] rem_digit,
   output logic [b58_pkg::BYTE_W-1:0]  quo
);

   import b58_pkg::*;

   logic [BYTE_W-1:0]  q1;
   logic [DIGIT_W-1:0] r1;
   logic [Y_W-1:0]     y;
   logic [Q2_W-1:0]    q2;
   logic [Y_W-1:0]     y_rem;

   // carry + 256 * digit is split into 58 * q1 + (carry + r1); the small
   // remainder part is then reduced by parallel compares.
   assign q1 = QUOT_TAB[digit];
   assign r1 = REM_TAB[digit];
   assign y  = Y_W'(carry) + Y_W'(r1);

   always_comb begin
      q2 = '0;
      for (int j = 1; j <= Q2_MAX; j++) begin
         if (y >= Y_W'(j * RADIX)) begin
            q2 = Q2_W'(j);
         end
      end
   end

   assign y_rem     = y - Y_W'(int'(q2) * RADIX);
   assign rem_digit = y_rem[DIGIT_W-1:0];
   assign quo       = BYTE_W'(Y_W'(q1) + Y_W'(q2));

endmodule

// File: rtl/base58_encoder.sv
// Each byte is taken in the idle state; a byte that enters the digit walk is
// then primed with a RAM read and walks N base-58 digits (at most 45 at the
// default size), one digit per cycle through the shared divide-by-58 unit.
// After the final byte, trimming reads and checks digits from the top down;
// then leading '1's go out and each base-58 character is read from RAM.
// Synchronous reset clears all control state; the digit RAM is not cleared.
module base58_encoder #(
   parameter int MAX_BYTES = b58_pkg::MAX_BYTES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [b58_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                       req_last_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [b58_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                       rsp_last_char,
   output logic                       rsp_overflow
);

   import b58_pkg::*;

   localparam int DIGITS = MAX_BYTES * LOG_NUM / LOG_DEN + 1;
   localparam int IW     = $clog2(DIGITS + 1);
   localparam int AW     = $clog2(DIGITS);
   localparam int CW     = $clog2(MAX_BYTES + 1);

   state_type state_ff, state_in;

   logic [IW-1:0]     in_use_ff, in_use_in;
   logic [CW-1:0]     lead_ff, lead_in;
   logic              in_lead_ff, in_lead_in;
   logic [CW-1:0]     taken_ff, taken_in;
   logic              ovf_ff, ovf_in;
   logic [BYTE_W-1:0] carry_ff, carry_in;
   logic [IW-1:0]     idx_ff, idx_in;
   logic              last_ff, last_in;
   logic [IW-1:0]     top_ff, top_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_out_char_ff, rsp_out_char_in;
   logic              rsp_last_char_ff, rsp_last_char_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [DIGIT_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [DIGIT_W-1:0] rd_data;

   logic [DIGIT_W-1:0] digit_cur;
   logic [DIGIT_W-1:0] rem_digit;
   logic [BYTE_W-1:0]  quo;

   logic          req_fire;
   logic          slot_free;
   logic          taking;
   logic          absorb_start;
   logic          step_more;
   logic [IW-1:0] idx_next;
   logic [IW-1:0] top_m1;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign taking    = (taken_ff < CW'(MAX_BYTES));
   assign absorb_start = taking && !(in_lead_ff && (req_data_byte == '0))
                         && ((req_data_byte != '0) || (in_use_ff != '0));
   assign idx_next  = idx_ff + 1'b1;
   assign top_m1    = top_ff - 1'b1;

   // Digits above the fill count have never been written for this string and
   // count as zero.
   assign digit_cur = (idx_ff < in_use_ff) ? rd_data : '0;
   assign step_more = ((quo != '0) || (idx_next < in_use_ff)) && (idx_next < IW'(DIGITS));

   b58_digit_unit u_digit (
      .digit     (digit_cur),
      .carry     (carry_ff),
      .rem_digit (rem_digit),
      .quo       (quo)
   );

   b58_ram #(
      .WIDTH (DIGIT_W),
      .DEPTH (DIGITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (absorb_start) begin
                  state_in = ST_PRIME;
               end else if (req_last_byte) begin
                  state_in = ST_TRIM_RD;
               end
            end
         end
         ST_PRIME: begin
            state_in = ST_ABSORB;
         end
         ST_ABSORB: begin
            if (!step_more) begin
               state_in = last_ff ? ST_TRIM_RD : ST_IDLE;
            end
         end
         ST_TRIM_RD: begin
            state_in = (top_ff == '0) ? ST_ONES : ST_TRIM_CHK;
         end
         ST_TRIM_CHK: begin
            state_in = (rd_data == '0) ? ST_TRIM_RD : ST_ONES;
         end
         ST_ONES: begin
            if (lead_ff == '0) begin
               state_in = ST_DIG_RD;
            end
         end
         ST_DIG_RD: begin
            state_in = (top_ff == '0) ? ST_IDLE : ST_DIG_OUT;
         end
         ST_DIG_OUT: begin
            if (slot_free) begin
               state_in = ST_DIG_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      in_use_ff_hold: begin
         in_use_in  = in_use_ff;
         lead_in    = lead_ff;
         in_lead_in = in_lead_ff;
         taken_in   = taken_ff;
         ovf_in     = ovf_ff;
         carry_in   = carry_ff;
         idx_in     = idx_ff;
         last_in    = last_ff;
         top_in     = top_ff;
      end
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_out_char_in  = rsp_out_char_ff;
      rsp_last_char_in = rsp_last_char_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rem_digit;
      rd_en   = 1'b0;
      rd_addr = idx_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in  = req_last_byte;
               carry_in = req_data_byte;
               idx_in   = '0;
               if (!taking) begin
                  ovf_in = 1'b1;
               end else begin
                  taken_in = taken_ff + 1'b1;
                  if (in_lead_ff && (req_data_byte == '0)) begin
                     lead_in = lead_ff + 1'b1;
                  end else begin
                     in_lead_in = 1'b0;
                  end
               end
               if (!absorb_start) begin
                  top_in = in_use_ff;
               end
            end
         end
         ST_PRIME: begin
            rd_en = 1'b1;
         end
         ST_ABSORB: begin
            wr_en    = 1'b1;
            carry_in = quo;
            idx_in   = idx_next;
            rd_en    = step_more;
            rd_addr  = idx_next[AW-1:0];
            if (!step_more) begin
               in_use_in = idx_next;
               top_in    = idx_next;
            end
         end
         ST_TRIM_RD: begin
            if (top_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = top_m1[AW-1:0];
            end
         end
         ST_TRIM_CHK: begin
            if (rd_data == '0) begin
               top_in = top_m1;
            end
         end
         ST_ONES: begin
            if ((lead_ff != '0) && slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_out_char_in  = b58_char('0);
               rsp_last_char_in = (lead_ff == CW'(1)) && (top_ff == '0);
               rsp_overflow_in  = ovf_ff;
               lead_in          = lead_ff - 1'b1;
            end
         end
         ST_DIG_RD: begin
            if (top_ff != '0) begin
               rd_en   = 1'b1;
               rd_addr = top_m1[AW-1:0];
               top_in  = top_m1;
            end else begin
               in_use_in  = '0;
               lead_in    = '0;
               in_lead_in = 1'b1;
               taken_in   = '0;
               ovf_in     = 1'b0;
            end
         end
         ST_DIG_OUT: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_out_char_in  = b58_char(rd_data);
               rsp_last_char_in = (top_ff == '0);
               rsp_overflow_in  = ovf_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_use_ff    <= '0;
         lead_ff      <= '0;
         in_lead_ff   <= 1'b1;
         taken_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         top_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         lead_ff      <= lead_in;
         in_lead_ff   <= in_lead_in;
         taken_ff     <= taken_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         top_ff       <= top_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff         <= carry_in;
      rsp_out_char_ff  <= rsp_out_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_out_char_ff;
   assign rsp_last_char = rsp_last_char_ff;
   assign rsp_overflow  = rsp_overflow_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      in_use_ff <= IW'(DIGITS))
      else $error("Digit fill count exceeds the store depth.");

   a_lead_taken: assert property (@(posedge clock) disable iff (reset)
      lead_ff <= taken_ff)
      else $error("Leading zero count exceeds the bytes taken.");

   a_top_fill: assert property (@(posedge clock) disable iff (reset)
      top_ff <= in_use_ff)
      else $error("Output digit pointer lies above the fill count.");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIG_OUT |-> rd_data < DIGIT_W'(RADIX))
      else $error("Stored digit read for output is not a base-58 digit.");
`endif

endmodule
